// ===== rtl/slc_pkg.sv =====
// shared types and constants for the signed log compressor
// no dependencies

package slc_pkg;

    localparam int SAMPLE_W           = 32;
    localparam int RESULT_W           = 21;
    localparam int LOG2_FRAC          = 28;
    localparam int Z_W                = 32;
    localparam int E_W                = 5;
    localparam int A_W                = E_W + LOG2_FRAC;
    localparam int K_W                = 30;
    localparam int P_W                = A_W + K_W;
    localparam int SUM_W              = 64;
    localparam int IN_FRAC_BITS_DEF   = 16;
    localparam int OUT_FRAC_BITS_DEF  = 16;

    localparam logic [K_W-1:0] K_LN2     = 30'd744261118;
    localparam logic [K_W-1:0] K_LOG10_2 = 30'd323228497;

    localparam logic [SUM_W-1:0] MAG_POS_MAX = SUM_W'((64'd1 << (RESULT_W - 1)) - 64'd1);
    localparam logic [SUM_W-1:0] MAG_NEG_MAX = SUM_W'(64'd1 << (RESULT_W - 1));

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_BASE = 1'b0;

    localparam logic BASE_NATURAL = 1'b0;

    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic [E_W-1:0]       e;
        logic [LOG2_FRAC-1:0] frac;
        logic [Z_W-1:0]       z;
    } t_sq_bus;

endpackage

// ===== rtl/slc_front.sv =====
// front end: magnitude, offset by one, leading-one search and mantissa normalize
// depends on slc_pkg

module slc_front import slc_pkg::*; #(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_sq_bus             o_bus
);

    logic                r_a_valid;
    logic                r_a_neg;
    logic [Z_W-1:0]      r_a_v;
    logic [Z_W-1:0]      n_a_mag;
    logic [Z_W-1:0]      n_a_v;
    logic [E_W-1:0]      n_e;
    t_sq_bus             n_bus;
    t_sq_bus             r_bus;

    always_comb begin
        n_a_mag = i_sample[SAMPLE_W-1] ? Z_W'(-i_sample) : Z_W'(i_sample);
        n_a_v   = n_a_mag + Z_W'(64'd1 << IN_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg <= i_sample[SAMPLE_W-1];
            r_a_v   <= n_a_v;
        end
    end

    always_comb begin
        n_e = '0;
        for (int i = 0; i < Z_W; i++) begin
            if (r_a_v[i]) begin
                n_e = E_W'(i);
            end
        end
        n_bus.valid = r_a_valid;
        n_bus.neg   = r_a_neg;
        n_bus.e     = n_e;
        n_bus.frac  = '0;
        n_bus.z     = r_a_v << (E_W'(Z_W - 1) - n_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== rtl/slc_sqr_stage.sv =====
// one squaring step of the base-two logarithm, yields one fraction bit
// depends on slc_pkg

module slc_sqr_stage import slc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_sq_bus i_bus,
    output t_sq_bus o_bus
);

    logic [2*Z_W-1:0] n_sq;
    logic [Z_W:0]     n_t;
    t_sq_bus          n_bus;
    t_sq_bus          r_bus;

    always_comb begin
        n_sq  = (2*Z_W)'(i_bus.z) * (2*Z_W)'(i_bus.z);
        n_t   = n_sq[2*Z_W-1:Z_W-1];
        n_bus = i_bus;
        n_bus.frac = {i_bus.frac[LOG2_FRAC-2:0], n_t[Z_W]};
        n_bus.z    = n_t[Z_W] ? n_t[Z_W:1] : n_t[Z_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== rtl/slc_scale.sv =====
// base change by constant multiply, then rounding, sign and saturation
// depends on slc_pkg

module slc_scale import slc_pkg::*; #(
    parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_log_base,
    input  t_sq_bus                    i_bus,
    output logic                       o_valid,
    output logic signed [RESULT_W-1:0] o_result
);

    localparam int RND_POS = 2*LOG2_FRAC + 1 - OUT_FRAC_BITS;
    localparam int SHIFT   = RND_POS + 1;

    logic [A_W-1:0]             n_a;
    logic [K_W-1:0]             n_k;
    logic                       r_p_valid;
    logic                       r_p_neg;
    logic [P_W-1:0]             r_p;
    logic [SUM_W-1:0]           n_sum;
    logic [SUM_W-1:0]           n_mag;
    logic [SUM_W-1:0]           n_lim;
    logic [SUM_W-1:0]           n_sat;
    logic signed [RESULT_W-1:0] n_result;
    logic                       r_res_valid;
    logic signed [RESULT_W-1:0] r_res;

    always_comb begin
        n_a = {i_bus.e - E_W'(IN_FRAC_BITS), i_bus.frac};
        n_k = (i_log_base == BASE_NATURAL) ? K_LN2 : K_LOG10_2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_neg <= i_bus.neg;
            r_p     <= P_W'(n_a) * P_W'(n_k);
        end
    end

    always_comb begin
        n_sum    = SUM_W'(r_p) + (SUM_W'(1) << RND_POS);
        n_mag    = n_sum >> SHIFT;
        n_lim    = r_p_neg ? MAG_NEG_MAX : MAG_POS_MAX;
        n_sat    = (n_mag > n_lim) ? n_lim : n_mag;
        n_result = r_p_neg ? -RESULT_W'(n_sat) : RESULT_W'(n_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_en) begin
            r_res_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_result;
        end
    end

    assign o_valid  = r_res_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/signed_log_compressor.sv =====
// signed log compressor top level: config register, pipeline, output register and skid
// depends on slc_pkg, slc_front, slc_sqr_stage, slc_scale
//
// usage
//   input channel: i_valid, i_sample, o_stall; a transfer happens on a rising edge with
//   i_valid high and o_stall low. output channel: o_valid, o_compressed, i_stall.
//   each sample gives one result, sign(x)*log(|x|+1), in the order taken.
//   log_base register at byte address 0 over the apb port: 0 natural, 1 base ten;
//   change it only when no transfer is in flight.
//   throughput: one sample per cycle while o_stall is low; the pipeline together with
//   the output register is 33 register stages, of which 28 each hold one 32x32 squaring
//   multiplier for one bit of the base-two logarithm.
//   o_stall is a registered flag: it rises only when the output register and the skid
//   register are both full, and then the pipeline holds still until the receiver
//   drops i_stall. no transfer is lost or repeated.
//   reset (i_rst_n low, synchronous) empties the pipeline and sets log_base to 0.

module signed_log_compressor import slc_pkg::*; #(
    parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_stall,
    output logic                       o_valid,
    output logic signed [RESULT_W-1:0] o_compressed,
    input  logic                       i_stall,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    logic                       r_log_base;
    logic [CFG_IDX_W-1:0]       n_cfg_idx;
    logic                       n_en;
    logic                       n_take;
    t_sq_bus                    w_bus [0:LOG2_FRAC];
    logic                       w_res_valid;
    logic signed [RESULT_W-1:0] w_res;
    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_out;
    logic                       r_skid_valid;
    logic signed [RESULT_W-1:0] r_skid;

    assign n_cfg_idx = paddr[APB_AW-1:APB_AW-CFG_IDX_W];
    assign pready    = 1'b1;
    assign prdata    = (n_cfg_idx == REG_LOG_BASE) ? APB_DW'(r_log_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_base <= BASE_NATURAL;
        end else if (psel && penable && pwrite && pready && n_cfg_idx == REG_LOG_BASE) begin
            r_log_base <= pwdata[0];
        end
    end

    assign n_en   = !r_skid_valid;
    assign n_take = r_out_valid && !i_stall;

    slc_front #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (n_en),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .o_bus    (w_bus[0])
    );

    for (genvar g = 0; g < LOG2_FRAC; g++) begin : g_sqr
        slc_sqr_stage u_sqr (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    slc_scale #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (n_en),
        .i_log_base (r_log_base),
        .i_bus      (w_bus[LOG2_FRAC]),
        .o_valid    (w_res_valid),
        .o_result   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (n_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || n_take) begin
            r_out_valid <= w_res_valid;
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (n_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || n_take) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_compressed = r_out;

endmodule

// ===== rtl/slc_checker.sv =====
// port-level checks for the signed log compressor, bound to the top level
// depends on slc_pkg and signed_log_compressor

module slc_checker import slc_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic signed [RESULT_W-1:0] o_compressed,
    input logic                       i_stall,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [APB_AW-1:0]          paddr,
    input logic [APB_DW-1:0]          pwdata,
    input logic [APB_DW-1:0]          prdata,
    input logic                       pready
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output side not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_compressed))
        else $error("stalled result changed or dropped");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without a stalled output");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output register empty");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[APB_AW-1] == REG_LOG_BASE
        && paddr == $past(paddr) |=> (paddr[APB_AW-1] != REG_LOG_BASE)
        || prdata[0] == $past(pwdata[0]))
        else $error("log_base readback differs from written value");

endmodule

bind signed_log_compressor slc_checker u_slc_checker (.*);
